>>> design/tdf_pkg.sv
package tdf_pkg;

    localparam int PRIME_W     = 32;
    localparam int EXP_W       = 5;
    localparam int MAX_RESULTS = 9;
    localparam int COUNT_W     = 4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic hit;
        logic next_d;
        logic emit_factor;
        logic emit_rest;
        logic emit_none;
    } tdf_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_small;
        logic div_done;
        logic q_ge_d;
        logic rem_zero;
        logic fact_last;
    } tdf_status_t;

endpackage

>>> design/tdf_divider.sv
module tdf_divider #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder,
    output logic             done
);
    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        ge        = (rem_shift >= {1'b0, dsr_reg});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = CNT_W'(WIDTH - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ge};
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> design/tdf_datapath.sv
module tdf_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [WIDTH-1:0]      number,
    input  tdf_pkg::tdf_cmd_t     cmd,
    output tdf_pkg::tdf_status_t  status,
    output logic                  valid,
    output logic [31:0]           prime,
    output logic [4:0]            exponent,
    output logic                  none,
    output logic                  last
);
    import tdf_pkg::*;

    logic [WIDTH-1:0]   rest_reg, rest_next;
    logic [WIDTH-1:0]   d_reg, d_next;
    logic [EXP_W-1:0]   expo_reg, expo_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               valid_reg, valid_next;
    logic [PRIME_W-1:0] prime_reg, prime_next;
    logic [EXP_W-1:0]   exp_out_reg, exp_out_next;
    logic               none_reg, none_next;
    logic               last_reg, last_next;

    logic [WIDTH-1:0]   quo;
    logic [WIDTH-1:0]   rem;
    logic               div_done;

    tdf_divider #(
        .WIDTH (WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rest_reg),
        .divisor   (d_reg),
        .quotient  (quo),
        .remainder (rem),
        .done      (div_done)
    );

    always_comb
    begin
        status.is_small  = (rest_reg <= WIDTH'(1));
        status.div_done  = div_done;
        status.q_ge_d    = (quo >= d_reg);
        status.rem_zero  = (rem == '0);
        // last if nothing remains or the result list is full
        status.fact_last = (rest_reg == WIDTH'(1))
                        || (count_reg == COUNT_W'(MAX_RESULTS - 1));
    end

    always_comb
    begin
        rest_next  = rest_reg;
        d_next     = d_reg;
        expo_next  = expo_reg;
        count_next = count_reg;

        if (cmd.load)
        begin
            rest_next  = number;
            d_next     = WIDTH'(2);
            expo_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (cmd.hit)
            begin
                rest_next = quo;
                expo_next = expo_reg + 1'b1;
            end
            if (cmd.next_d)
            begin
                d_next    = d_reg + 1'b1;
                expo_next = '0;
            end
            if (cmd.emit_factor)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next   = cmd.emit_factor | cmd.emit_rest | cmd.emit_none;
        prime_next   = prime_reg;
        exp_out_next = exp_out_reg;
        none_next    = none_reg;
        last_next    = last_reg;

        if (cmd.emit_factor)
        begin
            prime_next   = PRIME_W'(d_reg);
            exp_out_next = expo_reg;
            none_next    = 1'b0;
            last_next    = status.fact_last;
        end
        else if (cmd.emit_rest)
        begin
            prime_next   = PRIME_W'(rest_reg);
            exp_out_next = EXP_W'(1);
            none_next    = 1'b0;
            last_next    = 1'b1;
        end
        else if (cmd.emit_none)
        begin
            prime_next   = '0;
            exp_out_next = '0;
            none_next    = 1'b1;
            last_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg    <= rest_next;
        d_reg       <= d_next;
        expo_reg    <= expo_next;
        prime_reg   <= prime_next;
        exp_out_reg <= exp_out_next;
        none_reg    <= none_next;
        last_reg    <= last_next;
    end

    assign valid    = valid_reg;
    assign prime    = prime_reg;
    assign exponent = exp_out_reg;
    assign none     = none_reg;
    assign last     = last_reg;

endmodule

>>> design/tdf_ctrl.sv
module tdf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tdf_pkg::tdf_status_t status,
    output tdf_pkg::tdf_cmd_t    cmd,
    output logic                 busy
);
    import tdf_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_CHECK     = 6'b000010,
        ST_SCAN_GO   = 6'b000100,
        ST_SCAN_WAIT = 6'b001000,
        ST_OUT_GO    = 6'b010000,
        ST_OUT_WAIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.is_small)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN_GO;
                end
            end
            ST_SCAN_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                if (status.div_done)
                begin
                    if (!status.q_ge_d)
                    begin
                        // candidate squared exceeds what is left: leftover is prime
                        cmd.emit_rest = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (status.rem_zero)
                    begin
                        cmd.hit    = 1'b1;
                        state_next = ST_OUT_GO;
                    end
                    else
                    begin
                        cmd.next_d = 1'b1;
                        state_next = ST_SCAN_GO;
                    end
                end
            end
            ST_OUT_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.hit    = 1'b1;
                        state_next = ST_OUT_GO;
                    end
                    else
                    begin
                        cmd.emit_factor = 1'b1;
                        if (status.fact_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.next_d = 1'b1;
                            state_next = ST_SCAN_GO;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> design/trial_division_factorizer.sv
// Trial divisions: one per candidate divisor plus one per prime divided out; 0 and 1
//   are answered without any division.
// Throughput: one transaction at a time, set by the bit-serial divider (one quotient
//   bit a cycle); worst case a prime near 2^WIDTH, about 2^(WIDTH/2) candidates.
// Reset: async, active low, clears control, divider and strobe; results cannot stall.
module trial_division_factorizer #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] number,
    output logic             busy,
    output logic             valid,
    output logic [31:0]      prime,
    output logic [4:0]       exponent,
    output logic             none,
    output logic             last
);
    import tdf_pkg::*;

    // controller to datapath commands and the status coming back
    tdf_cmd_t    cmd;
    tdf_status_t status;

    // The controller walks candidates from 2 upward. Each candidate costs one
    // division of the remaining value; the quotient gives the loop bound
    // (candidate <= quotient) and the remainder tells a hit. On a hit the
    // factor is divided out until the remainder is non-zero, then reported.
    tdf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Remaining value, candidate, exponent and result count, the shared
    // divider and the result registers.
    tdf_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .number   (number),
        .cmd      (cmd),
        .status   (status),
        .valid    (valid),
        .prime    (prime),
        .exponent (exponent),
        .none     (none),
        .last     (last)
    );

    // the final result of a transaction lands as the controller goes idle
    a_last_vs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (last == !busy))
        else $error("last flag disagrees with controller state");

    a_none_result: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && none) |-> (last && (prime == '0) && (exponent == '0)))
        else $error("empty result is malformed");

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !valid))
        else $error("accepted transaction did not start cleanly");

endmodule

>>> bench/trial_division_factorizer_tb.sv
`timescale 1ns / 1ps

module trial_division_factorizer_tb;
    import tdf_pkg::*;

    localparam int WIDTH = 32;
    // cycles for one trial division in the bit-serial divider, with some slack
    localparam int DIV_CYCLES = WIDTH + 3;
    // random values whose factoring would need more trial divisions than this
    // are put aside, so that the run stays short
    localparam int unsigned TRIAL_CAP = 600;
    localparam int N_RANDOM = 80;

    // one factor as the block reports it
    typedef struct {
        bit [PRIME_W-1:0] prime;
        bit [EXP_W-1:0]   exponent;
        bit               none;
        bit               last;
    } factor_t;

    // Expected factors of the numbers taken in, oldest first, and the check
    // of each factor the block gives against the head of that list.
    class factor_book;
        factor_t     awaited[$];
        int unsigned checked;
        int unsigned errors;
        int unsigned most_factors;
        int unsigned top_exponent;

        // Trial division on a 64-bit copy; returns the number of divisions,
        // which is what the block's run time follows.
        static function int unsigned factorize(bit [WIDTH-1:0] n, output factor_t res[$]);
            bit [63:0]   rest;
            bit [63:0]   d;
            bit [EXP_W-1:0] ex;
            int unsigned trials;
            factor_t     f;
            res.delete();
            rest = n;
            trials = 0;
            if (rest <= 1)
            begin
                f.prime = '0;
                f.exponent = '0;
                f.none = 1'b1;
                f.last = 1'b1;
                res.push_back(f);
                return 1;
            end
            for (d = 2; d <= rest / d && res.size() < MAX_RESULTS; d++)
            begin
                trials++;
                if (rest % d == 0)
                begin
                    ex = '0;
                    while (rest % d == 0)
                    begin
                        rest = rest / d;
                        ex++;
                        trials++;
                    end
                    f.prime = d[PRIME_W-1:0];
                    f.exponent = ex;
                    f.none = 1'b0;
                    f.last = 1'b0;
                    res.push_back(f);
                end
            end
            // whatever is left above one is a prime of its own
            if (rest > 1 && res.size() < MAX_RESULTS)
            begin
                f.prime = rest[PRIME_W-1:0];
                f.exponent = EXP_W'(1);
                f.none = 1'b0;
                f.last = 1'b0;
                res.push_back(f);
            end
            res[res.size() - 1].last = 1'b1;
            return trials + 1;
        endfunction

        // Note one accepted transaction; returns a generous cycle budget for it,
        // four times the estimated work.
        function int unsigned note_input(bit [WIDTH-1:0] n);
            factor_t     res[$];
            int unsigned trials;
            trials = factorize(n, res);
            foreach (res[i])
            begin
                awaited.push_back(res[i]);
                if (res[i].exponent > top_exponent)
                    top_exponent = res[i].exponent;
            end
            if (res.size() > most_factors)
                most_factors = res.size();
            return 4 * (trials + 4) * DIV_CYCLES;
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(bit [PRIME_W-1:0] p, bit [EXP_W-1:0] e, bit nf, bit l);
            factor_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t ns: unexpected result prime %0d exponent %0d none %0b last %0b",
                         $time, p, e, nf, l);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (p != want.prime)
                report("prime", want.prime, p);
            if (e != want.exponent)
                report("exponent", want.exponent, e);
            if (nf != want.none)
                report("none", want.none, nf);
            if (l != want.last)
                report("last", want.last, l);
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic [WIDTH-1:0] number;
    logic             busy;
    logic             valid;
    logic [31:0]      prime;
    logic [4:0]       exponent;
    logic             none;
    logic             last;

    factor_book  book;
    int unsigned cycles;
    // watchdog limit; grows with the estimated work of every accepted transaction
    longint unsigned cycle_limit;
    int unsigned n_directed;
    int unsigned n_random;

    // small primes used to build random numbers that factor quickly
    int unsigned small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

    // directed values: zero and one, small primes and squares, a larger prime,
    // the highest power of two, all ones, alternating bit patterns, the most
    // distinct primes that fit (nine), and a high power of three
    bit [WIDTH-1:0] directed_numbers[20] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd12, 32'd25, 32'd36, 32'd49,
        32'd30030, 32'd65537, 32'd1000003, 32'h8000_0000, 32'hFFFF_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555, 32'd223092870, 32'd446185740,
        32'd3486784401, 32'd4294836225
    };

    trial_division_factorizer #(
        .WIDTH(WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .number  (number),
        .busy    (busy),
        .valid   (valid),
        .prime   (prime),
        .exponent(exponent),
        .none    (none),
        .last    (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // results cannot be held off, so every strobe is checked at once
    always @(posedge clk)
    begin
        if (rst_n && valid)
            book.check_result(prime, exponent, none, last);
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles <= cycle_limit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still awaited",
                 cycles, book.awaited.size());
        $display("trial_division_factorizer_tb failed");
        $finish;
    end

    // Drive one transaction; start stays high afterwards so that a
    // following transaction in the same burst follows without a gap.
    task automatic send_number(bit [WIDTH-1:0] n);
        @(negedge clk);
        start <= 1'b1;
        number <= n;
        do
            @(posedge clk);
        while (busy);
        cycle_limit += book.note_input(n);
    endtask

    // Hold start low for a number of cycles; number carries noise meanwhile.
    task automatic hold_off(int unsigned n_cycles);
        if (n_cycles == 0)
            return;
        @(negedge clk);
        start <= 1'b0;
        number <= $urandom;
        repeat (n_cycles - 1) @(negedge clk);
    endtask

    // Lower start and wait until every expected result has come.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (book.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Random numbers: mostly products of small primes (times a modest
    // cofactor), some full-width values cheap enough to factor, and a
    // little noise among the smallest values, zero and one included.
    function automatic bit [WIDTH-1:0] pick_number();
        int unsigned kind;
        bit [63:0]   v;
        bit [63:0]   p;
        bit [WIDTH-1:0] r;
        factor_t     scratch[$];
        kind = $urandom_range(0, 9);
        if (kind == 9)
            return $urandom_range(0, 40);
        if (kind >= 6)
        begin
            repeat (30)
            begin
                r = $urandom;
                if (factor_book::factorize(r, scratch) <= TRIAL_CAP)
                    return r;
            end
        end
        v = 1;
        repeat ($urandom_range(1, 24))
        begin
            p = small_primes[$urandom_range(0, 11)];
            if (v * p <= 64'hFFFF_FFFF)
                v = v * p;
        end
        if ($urandom_range(0, 1))
        begin
            p = $urandom_range(2, 5000);
            if (v * p <= 64'hFFFF_FFFF)
                v = v * p;
        end
        return v[WIDTH-1:0];
    endfunction

    initial
    begin
        int unsigned burst;
        int unsigned gap;
        book = new();
        cycle_limit = 200000;
        n_directed = 0;
        n_random = 0;
        rst_n = 1'b0;
        start = 1'b0;
        number = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: first half back to back, the rest with short gaps
        foreach (directed_numbers[i])
        begin
            send_number(directed_numbers[i]);
            n_directed++;
            if (i >= $size(directed_numbers) / 2)
                hold_off($urandom_range(0, 12));
        end

        // pause with the block fully drained before the random part
        drain();
        hold_off(5);

        // random: bursts of random length, gaps of random length, some bursts
        // with no gap at all
        while (n_random < N_RANDOM)
        begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && n_random < N_RANDOM)
            begin
                send_number(pick_number());
                n_random++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            hold_off(gap);
            // at random, a further full drain midway through
            if (n_random >= N_RANDOM / 2 && n_random - burst < N_RANDOM / 2 + 8
                && $urandom_range(0, 3) == 0)
                drain();
        end

        drain();
        // latency tail: any stray strobe after the last result is caught here
        repeat (100) @(posedge clk);

        $display("%0d transactions (%0d directed, %0d random), %0d results checked",
                 n_directed + n_random, n_directed, n_random, book.checked);
        $display("up to %0d factors in one transaction, exponents up to %0d, %0d cycles",
                 book.most_factors, book.top_exponent, cycles);
        if (book.errors == 0)
            $display("trial_division_factorizer_tb passed");
        else
            $display("trial_division_factorizer_tb failed");
        $finish;
    end

endmodule
